[rtl/core/crc8_crc16_frame_check_top_assert.svh]
// Assertion macros for the frame check core.
`ifndef CRC8_CRC16_FRAME_CHECK_TOP_ASSERT_SVH
`define CRC8_CRC16_FRAME_CHECK_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define FCHK_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FCHK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fchk_pkg.sv]
// Shared types, constants and CRC byte update functions for the frame check core.
package fchk_pkg;

  localparam logic [7:0]  CRC8_INIT   = 8'hFF;
  localparam logic [7:0]  POLY8_REFL  = 8'h8C;
  localparam logic [15:0] CRC16_INIT  = 16'hFFFF;
  localparam logic [15:0] POLY16_REFL = 16'h8408;

  // Configuration register indexes
  localparam logic CFG_IDX_WIDTH_SEL = 1'b0;
  localparam logic CFG_IDX_TRAILER   = 1'b1;

  typedef struct packed {
    logic width_sel;     // 0: CRC-8, 1: CRC-16
    logic trailer_mode;  // 1: hold back and compare check bytes
  } fchk_cfg_t;

  typedef struct packed {
    logic restart;       // restart the frame state this cycle
    logic init_wide;     // width to take the init value from
  } fchk_ctl_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } fchk_item_t;

  function automatic logic [15:0] crc_init(logic wide);
    logic [15:0] r;
    r = wide ? CRC16_INIT : {8'h00, CRC8_INIT};
    return r;
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ POLY16_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ POLY8_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/core/fchk_byte_if.sv]
// Byte channel: one frame byte per transaction with a last-byte mark.
interface fchk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

[rtl/core/fchk_result_if.sv]
// Result channel: one frame check report per transaction.
interface fchk_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] computed_crc;
  logic [15:0] received_check;
  logic        check_match;
  logic        frame_too_short;

  modport source (output valid, output computed_crc, output received_check,
                  output check_match, output frame_too_short, input ready);
  modport sink   (input valid, input computed_crc, input received_check,
                  input check_match, input frame_too_short, output ready);
endinterface

[rtl/core/crc8_crc16_frame_check_top.sv]
// Frame check core: one byte per cycle, reflected CRC-8 (poly 0x8C) or CRC-16
// (poly 0x8408), optional trailer compare. Sustained rate is one byte
// transaction per clock, but for the stall below; a final byte passes
// through the input register, and the combinational byte update then
// writes the result register, which presents the report. The result
// register holds a report until it is taken; input stalls only when a final
// byte meets a report still waiting.
// A configuration write restarts the frame state with the new settings.
module crc8_crc16_frame_check_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic cfg_wdata_i,
  fchk_byte_if.sink     in_if,
  fchk_result_if.source out_if
);
  import fchk_pkg::*;

  fchk_cfg_t  cfg_q, cfg_d;
  fchk_ctl_t  ctl;
  logic       s1_valid;
  fchk_item_t s1_item;
  logic       take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDTH_SEL: cfg_d.width_sel    = cfg_wdata_i;
        CFG_IDX_TRAILER:   cfg_d.trailer_mode = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
    ctl.restart   = cfg_we_i;
    ctl.init_wide = cfg_d.width_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{width_sel: 1'b1, trailer_mode: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fchk_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .take_i  (take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  fchk_frame_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ctl_i      (ctl),
    .s1_valid_i (s1_valid),
    .s1_item_i  (s1_item),
    .take_o     (take),
    .out_if     (out_if)
  );

endmodule

[rtl/core/fchk_in_stage.sv]
// Input register: captures one byte transaction ahead of the CRC update.
module fchk_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  fchk_byte_if.sink           in_if,
  input  logic                take_i,
  output logic                valid_o,
  output fchk_pkg::fchk_item_t item_o
);
  import fchk_pkg::*;

  logic       valid_q, valid_d;
  fchk_item_t item_q;
  logic       accept;

  assign in_if.ready = !valid_q || take_i;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte  <= in_if.data_byte;
      item_q.frame_last <= in_if.frame_last;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/core/fchk_frame_engine.sv]
// Frame state, combinational CRC byte update and registered result.
module fchk_frame_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fchk_pkg::fchk_cfg_t  cfg_i,
  input  fchk_pkg::fchk_ctl_t  ctl_i,
  input  logic                 s1_valid_i,
  input  fchk_pkg::fchk_item_t s1_item_i,
  output logic                 take_o,
  fchk_result_if.source        out_if
);
  import fchk_pkg::*;
  `include "crc8_crc16_frame_check_top_assert.svh"

  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  seen_q, seen_d;
  logic        out_valid_q;
  logic        out_free;
  logic        last_take;

  logic        feed_en;
  logic [7:0]  feed_byte;
  logic [15:0] crc_upd;
  logic [1:0]  seen_upd;
  logic [15:0] res_crc, res_rx;
  logic        res_short, res_match;

  logic [15:0] crc_res_q, rx_res_q;
  logic        match_res_q, short_res_q;

  assign out_free  = !out_valid_q || out_if.ready;
  assign take_o    = s1_valid_i && (!s1_item_i.frame_last || out_free);
  assign last_take = take_o && s1_item_i.frame_last;

  always_comb begin
    // trailer mode feeds the byte leaving the delay line, once it is full
    if (cfg_i.trailer_mode) begin
      feed_en   = cfg_i.width_sel ? (seen_q >= 2'd2) : (seen_q >= 2'd1);
      feed_byte = cfg_i.width_sel ? held0_q : held1_q;
    end else begin
      feed_en   = 1'b1;
      feed_byte = s1_item_i.data_byte;
    end

    crc_upd = crc_q;
    if (feed_en) begin
      crc_upd = cfg_i.width_sel ? crc16_byte(crc_q, feed_byte)
                                : {8'h00, crc8_byte(crc_q[7:0], feed_byte)};
    end
    seen_upd = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;

    res_crc   = cfg_i.width_sel ? crc_upd : {8'h00, crc_upd[7:0]};
    res_rx    = 16'h0000;
    res_short = 1'b0;
    if (cfg_i.trailer_mode) begin
      res_rx    = cfg_i.width_sel ? {s1_item_i.data_byte, held1_q}
                                  : {8'h00, s1_item_i.data_byte};
      res_short = (seen_upd <= 2'd2);
    end
    res_match = cfg_i.trailer_mode && !res_short && (res_crc == res_rx);

    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    seen_d  = seen_q;
    if (ctl_i.restart) begin
      crc_d   = crc_init(ctl_i.init_wide);
      held0_d = 8'h00;
      held1_d = 8'h00;
      seen_d  = 2'd0;
    end else if (take_o) begin
      if (s1_item_i.frame_last) begin
        crc_d   = crc_init(cfg_i.width_sel);
        held0_d = 8'h00;
        held1_d = 8'h00;
        seen_d  = 2'd0;
      end else begin
        crc_d   = crc_upd;
        held0_d = held1_q;
        held1_d = s1_item_i.data_byte;
        seen_d  = seen_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC16_INIT;
      held0_q     <= 8'h00;
      held1_q     <= 8'h00;
      seen_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      seen_q  <= seen_d;
      if (out_free) begin
        out_valid_q <= last_take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_take) begin
      crc_res_q   <= res_crc;
      rx_res_q    <= res_rx;
      match_res_q <= res_match;
      short_res_q <= res_short;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.computed_crc    = crc_res_q;
  assign out_if.received_check  = rx_res_q;
  assign out_if.check_match     = match_res_q;
  assign out_if.frame_too_short = short_res_q;

  `FCHK_ASSERT(a_short_no_match, !(out_valid_q && match_res_q && short_res_q),
               "short frame reported as a match")
  `FCHK_ASSERT(a_crc8_high_zero,
               !(out_valid_q && !cfg_i.width_sel && (crc_res_q[15:8] != 8'h00)),
               "CRC-8 result has high byte set")
  `FCHK_ASSERT_NEXT(a_frame_end_clears, last_take, seen_q == 2'd0,
                    "frame state not cleared after final byte")
  `FCHK_ASSERT_NEXT(a_stalled_result_kept, out_valid_q && !out_if.ready,
                    out_valid_q && $stable(crc_res_q) && $stable(rx_res_q),
                    "pending result lost while stalled")

endmodule

[dv/crc8_crc16_frame_check_top_tb.sv]
// Testbench for the CRC-8/CRC-16 frame check core: directed frames, then random traffic.
`timescale 1ns / 1ps

module crc8_crc16_frame_check_top_tb;
  import fchk_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_TARGET   = 450;

  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] rx;
    logic        match;
    logic        too_short;
  } frame_report_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_idx;
  logic cfg_wdata;

  fchk_byte_if   in_ch ();
  fchk_result_if out_ch ();

  crc8_crc16_frame_check_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  frame_report_t frame_reports_due[$];
  logic [7:0]    frame_buf[$];
  frame_report_t got_rpt;

  int errors      = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit no_gaps     = 0;
  int rx_mode     = 0;
  int rx_cnt      = 0;

  // Shadow of the core's configuration and frame state
  logic        sh_wide;
  logic        sh_trailer;
  logic [15:0] sh_crc;
  logic [7:0]  sh_older;
  logic [7:0]  sh_newer;
  logic [1:0]  sh_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reflected bitwise update; the narrow case lives in the low byte
  function automatic logic [15:0] crc_next(logic wide, logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    logic [15:0] poly;
    c    = wide ? (acc ^ {8'h00, b}) : {8'h00, acc[7:0] ^ b};
    poly = wide ? POLY16_REFL : {8'h00, POLY8_REFL};
    repeat (8) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    return c;
  endfunction

  function automatic logic [15:0] crc_seed();
    return sh_wide ? CRC16_INIT : {8'h00, CRC8_INIT};
  endfunction

  function automatic void frame_state_clear();
    sh_crc   = crc_seed();
    sh_older = 8'h00;
    sh_newer = 8'h00;
    sh_count = 2'd0;
  endfunction

  // Advance the shadow by one accepted byte; queue a report on the final byte
  function automatic void crc_track_byte(logic [7:0] b, logic last);
    frame_report_t r;
    if (sh_trailer) begin
      if (sh_count >= (sh_wide ? 2 : 1))
        sh_crc = crc_next(sh_wide, sh_crc, sh_wide ? sh_older : sh_newer);
    end else begin
      sh_crc = crc_next(sh_wide, sh_crc, b);
    end
    sh_older = sh_newer;
    sh_newer = b;
    if (sh_count < 2'd3)
      sh_count++;
    if (last) begin
      r.crc       = sh_wide ? sh_crc : {8'h00, sh_crc[7:0]};
      r.rx        = !sh_trailer ? 16'h0000 : (sh_wide ? {sh_newer, sh_older} : {8'h00, sh_newer});
      r.too_short = sh_trailer && (sh_count <= 2'd2);
      r.match     = sh_trailer && !r.too_short && (r.crc == r.rx);
      frame_reports_due.push_back(r);
      frame_state_clear();
    end
  endfunction

  task automatic note_failure(input string what, input frame_report_t want,
                              input frame_report_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: exp crc=%h rx=%h match=%b short=%b, got crc=%h rx=%h match=%b short=%b",
               $time, what, want.crc, want.rx, want.match, want.too_short,
               got.crc, got.rx, got.match, got.too_short);
  endtask

  // Report checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_rpt = '{out_ch.computed_crc, out_ch.received_check,
                  out_ch.check_match, out_ch.frame_too_short};
      if (frame_reports_due.size() == 0) begin
        note_failure("unexpected report", '0, got_rpt);
      end else if (frame_reports_due[0] !== got_rpt) begin
        note_failure("report mismatch", frame_reports_due[0], got_rpt);
        void'(frame_reports_due.pop_front());
      end else begin
        void'(frame_reports_due.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Report sink back-pressure in randomly drawn modes
  always @(negedge clk_i) begin
    if (rx_cnt % 48 == 0)
      rx_mode = $urandom_range(0, 3);
    rx_cnt++;
    case (rx_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
      2:       out_ch.ready <= (rx_cnt % 3 != 0);
      default: out_ch.ready <= (rx_cnt % 16 >= 10);
    endcase
  end

  // valid is left high after a transaction; the next negedge decides what follows
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.frame_last <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
    crc_track_byte(b, last);
  endtask

  task automatic send_frame(input bit close);
    foreach (frame_buf[i])
      send_byte(frame_buf[i], close && (i == frame_buf.size() - 1));
  endtask

  function automatic void fill_random(int n);
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Append the check over frame_buf, little-endian for CRC-16, optionally with one bit flipped
  function automatic void append_check(bit corrupt);
    logic [15:0] acc;
    acc = crc_seed();
    foreach (frame_buf[i])
      acc = crc_next(sh_wide, acc, frame_buf[i]);
    if (corrupt)
      acc = acc ^ (16'h0001 << $urandom_range(0, sh_wide ? 15 : 7));
    frame_buf.push_back(acc[7:0]);
    if (sh_wide)
      frame_buf.push_back(acc[15:8]);
  endfunction

  function automatic int frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(0, 7);
    else if (r < 95)
      return $urandom_range(8, 24);
    return $urandom_range(25, 48);
  endfunction

  // Stop sending, wait for every report, then let the pipeline empty
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (frame_reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    if (idx == CFG_IDX_WIDTH_SEL)
      sh_wide = val;
    else
      sh_trailer = val;
    frame_state_clear();
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic test_crc16_trailer_defaults();
    frame_buf = '{8'h31};
    append_check(1'b0);
    send_frame(1'b1);
    frame_buf = '{8'h00};
    append_check(1'b1);
    send_frame(1'b1);
  endtask

  task automatic test_crc16_short_frames();
    frame_buf = '{8'hFF};
    send_frame(1'b1);
    frame_buf = '{8'h00, 8'hFF};
    send_frame(1'b1);
  endtask

  task automatic test_crc8_trailer();
    drain();
    write_reg(CFG_IDX_WIDTH_SEL, 1'b0);
    frame_buf = '{8'hA5};
    send_frame(1'b1);
    frame_buf = '{8'h00, 8'hFF};
    append_check(1'b0);
    send_frame(1'b1);
    // check byte plus one data byte is still too short
    frame_buf = '{8'h7E};
    append_check(1'b0);
    send_frame(1'b1);
  endtask

  task automatic test_append_mode();
    drain();
    write_reg(CFG_IDX_TRAILER, 1'b0);
    frame_buf = '{8'hFF};
    send_frame(1'b1);
    drain();
    write_reg(CFG_IDX_WIDTH_SEL, 1'b1);
    frame_buf = '{8'h00, 8'hFF};
    send_frame(1'b1);
  endtask

  task automatic test_restart_on_write();
    drain();
    frame_buf = '{8'h12, 8'h34};
    send_frame(1'b0);
    drain();
    write_reg(CFG_IDX_TRAILER, 1'b1);
    frame_buf = '{8'h5A};
    append_check(1'b0);
    send_frame(1'b1);
  endtask

  task automatic test_random_traffic();
    int phase;
    int kind;
    bit paused;
    phase  = 0;
    paused = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      if (phase < 4) begin
        write_reg(CFG_IDX_WIDTH_SEL, phase[0]);
        write_reg(CFG_IDX_TRAILER, phase[1]);
      end else begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_IDX_WIDTH_SEL, 1'($urandom_range(0, 1)));
          1: write_reg(CFG_IDX_TRAILER, 1'($urandom_range(0, 1)));
          default: begin
            write_reg(CFG_IDX_WIDTH_SEL, 1'($urandom_range(0, 1)));
            write_reg(CFG_IDX_TRAILER, 1'($urandom_range(0, 1)));
          end
        endcase
      end
      no_gaps = (phase % 3 == 2);
      repeat ($urandom_range(3, 10)) begin
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
          fill_random(frame_len());
          append_check(1'b0);
        end else if (kind < 16) begin
          fill_random(frame_len());
          append_check(1'b1);
        end else begin
          fill_random($urandom_range(1, 3));
        end
        send_frame(1'b1);
        if (!paused && items_sent > ITEM_TARGET / 2) begin
          drain();
          paused = 1;
        end
      end
      // unfinished frame, dropped by the next register write
      if ($urandom_range(0, 4) == 0) begin
        fill_random($urandom_range(1, 5));
        send_frame(1'b0);
      end
      phase++;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_IDX_WIDTH_SEL;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.frame_last = 1'b0;
    out_ch.ready     = 1'b0;
    sh_wide          = 1'b1;
    sh_trailer       = 1'b1;
    frame_state_clear();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_crc16_trailer_defaults();
    test_crc16_short_frames();
    test_crc8_trailer();
    test_append_mode();
    test_restart_on_write();
    test_random_traffic();

    drain();
    if (frame_reports_due.size() != 0)
      errors++;
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
